[sv/bsi_pkg.sv]
// ----------------------------------------------------------------------------
// Breakpoint schedule interpolator package
// Shared constants: widths, table size, function and register codes, divider
// step count.
// ----------------------------------------------------------------------------
package bsi_pkg;

   // table geometry
   localparam int MAX_BREAKPOINTS = 16;
   localparam int SLOT_W          = 4;
   localparam int COUNT_W         = 5;

   // payload widths
   localparam int TIME_W  = 32;
   localparam int VALUE_W = 24;
   localparam int PROD_W  = TIME_W + VALUE_W;

   // divider runs one quotient bit per cycle over the full product
   localparam int DIV_STEPS = PROD_W;
   localparam int DIV_CNT_W = 6;

   // request function codes
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // register indexes
   localparam int  CSR_INDEX_W = 1;
   localparam int  CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERP_MODE      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BREAKPOINT_COUNT = 1'b1;

   // interpolation modes
   localparam logic MODE_CONSTANT = 1'b0;
   localparam logic MODE_LINEAR   = 1'b1;

   // reset value of the breakpoint count register
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd2;

endpackage

[sv/breakpoint_schedule_interpolator_unit.sv]
// ----------------------------------------------------------------------------
// Breakpoint schedule interpolator
// Piecewise constant or linear temperature schedule over a 16-entry
// breakpoint table, with one shared restoring divider for interpolation.
// ----------------------------------------------------------------------------
// Sequence: a load writes the table on acceptance, no result. A sample reads
//   the table, steps the pointer, takes the segment start, then outputs in
//   constant mode or at the table end, else checks the span; if positive it
//   multiplies, runs 56 divider steps (a bit a cycle), saturates. Loads go back
//   to back; a sample stalls requests until output, longer if a result is held.
// Reset: synchronous; clears sequencer, pointer and output valid, sets
//   constant mode and a count of 2; the table is not cleared.
module breakpoint_schedule_interpolator_unit
   import bsi_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [SLOT_W-1:0]      req_entry_index,
   input  logic [TIME_W-1:0]      req_entry_time,
   input  logic [VALUE_W-1:0]     req_entry_value,
   input  logic [TIME_W-1:0]      req_update_index,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_W-1:0]     rsp_temperature,
   output logic [SLOT_W-1:0]      rsp_segment,
   output logic                   rsp_past_end,
   // register write port
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RD_NEXT = 4'd1;
   localparam logic [3:0] S_ADVANCE = 4'd2;
   localparam logic [3:0] S_SEG0    = 4'd3;
   localparam logic [3:0] S_SEG1    = 4'd4;
   localparam logic [3:0] S_MUL     = 4'd5;
   localparam logic [3:0] S_DIV     = 4'd6;
   localparam logic [3:0] S_FIN     = 4'd7;
   localparam logic [3:0] S_OUT     = 4'd8;

   // breakpoint table
   logic [TIME_W-1:0]  times_mem  [MAX_BREAKPOINTS];
   logic [VALUE_W-1:0] values_mem [MAX_BREAKPOINTS];
   logic [TIME_W-1:0]  rd_time_ff;
   logic [VALUE_W-1:0] rd_value_ff;
   logic [SLOT_W-1:0]  rd_addr;

   // control state
   logic [3:0]         state_ff, state_in;
   logic [SLOT_W-1:0]  ptr_ff, ptr_in;
   logic               mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [TIME_W-1:0]    u_ff, u_in;
   logic                 at_end_ff, at_end_in;
   logic [TIME_W-1:0]    t0_ff, t0_in;
   logic [VALUE_W-1:0]   v0_ff, v0_in;
   logic [VALUE_W-1:0]   dv_mag_ff, dv_mag_in;
   logic [TIME_W-1:0]    du_mag_ff, du_mag_in;
   logic                 neg_ff, neg_in;
   logic [TIME_W-1:0]    span_ff, span_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   res_ff, res_in;
   logic [VALUE_W-1:0]   rsp_temperature_ff, rsp_temperature_in;
   logic [SLOT_W-1:0]    rsp_segment_ff, rsp_segment_in;
   logic                 rsp_past_end_ff, rsp_past_end_in;

   // combinational helpers
   logic                 req_accept;
   logic                 out_free;
   logic [SLOT_W-1:0]    last_slot;
   logic                 advance;
   logic [SLOT_W-1:0]    adv_ptr;
   logic [VALUE_W:0]     dv;
   logic [TIME_W:0]      du;
   logic [PROD_W-1:0]    prod;
   logic [TIME_W:0]      rem_shift;
   logic [TIME_W+1:0]    div_diff;
   logic                 div_ge;
   logic [PROD_W:0]      fin_sum;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   // clamp the breakpoint count into 2..MAX_BREAKPOINTS, take the last slot
   always_comb begin
      if (count_ff < COUNT_W'(2)) begin
         last_slot = SLOT_W'(1);
      end else if (count_ff > COUNT_W'(MAX_BREAKPOINTS)) begin
         last_slot = SLOT_W'(MAX_BREAKPOINTS - 1);
      end else begin
         last_slot = count_ff[SLOT_W-1:0] - SLOT_W'(1);
      end
   end

   // step the pointer when the next breakpoint time is reached
   assign advance = (ptr_ff < last_slot) && (u_ff >= rd_time_ff);
   assign adv_ptr = advance ? ptr_ff + SLOT_W'(1) : ptr_ff;

   // segment deltas, rd_* holds the segment end in S_SEG1
   assign dv   = {1'b0, rd_value_ff} - {1'b0, v0_ff};
   assign du   = {1'b0, u_ff} - {1'b0, t0_ff};
   assign prod = {{TIME_W{1'b0}}, dv_mag_ff} * {{VALUE_W{1'b0}}, du_mag_ff};

   // shared compare-subtract step of the restoring divider
   assign rem_shift = {rem_ff, quo_ff[PROD_W-1]};
   assign div_diff  = {1'b0, rem_shift} - {2'b00, span_ff};
   assign div_ge    = ~div_diff[TIME_W+1];

   // start value plus unsigned quotient, used for the positive direction
   assign fin_sum = {{(PROD_W-VALUE_W+1){1'b0}}, v0_ff} + {1'b0, quo_ff};

   // table read address per sequencer step
   always_comb begin
      unique case (state_ff)
         S_RD_NEXT: rd_addr = ptr_ff + SLOT_W'(1);
         S_ADVANCE: rd_addr = adv_ptr;
         S_SEG0:    rd_addr = ptr_ff + SLOT_W'(1);
         default:   rd_addr = ptr_ff;
      endcase
   end

   // sequencer and datapath next state
   always_comb begin
      state_in           = state_ff;
      ptr_in             = ptr_ff;
      mode_in            = mode_ff;
      count_in           = count_ff;
      rsp_valid_in       = rsp_valid_ff & rsp_stall;
      u_in               = u_ff;
      at_end_in          = at_end_ff;
      t0_in              = t0_ff;
      v0_in              = v0_ff;
      dv_mag_in          = dv_mag_ff;
      du_mag_in          = du_mag_ff;
      neg_in             = neg_ff;
      span_in            = span_ff;
      quo_in             = quo_ff;
      rem_in             = rem_ff;
      cnt_in             = cnt_ff;
      res_in             = res_ff;
      rsp_temperature_in = rsp_temperature_ff;
      rsp_segment_in     = rsp_segment_ff;
      rsp_past_end_in    = rsp_past_end_ff;

      // register writes must arrive only while idle; the block does not enforce this
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INTERP_MODE:      mode_in  = csr_data[0];
            CSR_BREAKPOINT_COUNT: count_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_func == FUNC_LOAD) begin
                  ptr_in = '0;
               end else begin
                  // clamp a pointer left beyond a lowered count
                  ptr_in   = (ptr_ff > last_slot) ? last_slot : ptr_ff;
                  u_in     = req_update_index;
                  state_in = S_RD_NEXT;
               end
            end
         end
         S_RD_NEXT: begin
            state_in = S_ADVANCE;
         end
         S_ADVANCE: begin
            ptr_in    = adv_ptr;
            at_end_in = (adv_ptr == last_slot);
            state_in  = S_SEG0;
         end
         S_SEG0: begin
            t0_in = rd_time_ff;
            v0_in = rd_value_ff;
            res_in = rd_value_ff;
            if (at_end_ff || (mode_ff == MODE_CONSTANT)) begin
               state_in = S_OUT;
            end else begin
               state_in = S_SEG1;
            end
         end
         S_SEG1: begin
            // a zero or negative span keeps the start value
            if (rd_time_ff > t0_ff) begin
               dv_mag_in = dv[VALUE_W] ? VALUE_W'(-dv) : dv[VALUE_W-1:0];
               du_mag_in = du[TIME_W] ? TIME_W'(-du) : du[TIME_W-1:0];
               neg_in    = dv[VALUE_W] ^ du[TIME_W];
               span_in   = rd_time_ff - t0_ff;
               state_in  = S_MUL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MUL: begin
            quo_in   = prod;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = div_ge ? div_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
            quo_in = {quo_ff[PROD_W-2:0], div_ge};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // apply the truncated quotient and saturate to the value range
            if (neg_ff) begin
               if ({{(PROD_W-VALUE_W){1'b0}}, v0_ff} < quo_ff) begin
                  res_in = '0;
               end else begin
                  res_in = v0_ff - quo_ff[VALUE_W-1:0];
               end
            end else if (fin_sum[PROD_W:VALUE_W] != '0) begin
               res_in = '1;
            end else begin
               res_in = fin_sum[VALUE_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_temperature_in = res_ff;
               rsp_segment_in     = ptr_ff;
               rsp_past_end_in    = at_end_ff;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ptr_ff       <= '0;
         mode_ff      <= MODE_CONSTANT;
         count_ff     <= COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      u_ff               <= u_in;
      at_end_ff          <= at_end_in;
      t0_ff              <= t0_in;
      v0_ff              <= v0_in;
      dv_mag_ff          <= dv_mag_in;
      du_mag_ff          <= du_mag_in;
      neg_ff             <= neg_in;
      span_ff            <= span_in;
      quo_ff             <= quo_in;
      rem_ff             <= rem_in;
      cnt_ff             <= cnt_in;
      res_ff             <= res_in;
      rsp_temperature_ff <= rsp_temperature_in;
      rsp_segment_ff     <= rsp_segment_in;
      rsp_past_end_ff    <= rsp_past_end_in;
   end

   // write a breakpoint on a load beat
   always_ff @(posedge clock) begin
      if (req_accept && (req_func == FUNC_LOAD)) begin
         times_mem[req_entry_index]  <= req_entry_time;
         values_mem[req_entry_index] <= req_entry_value;
      end
   end

   // registered table read
   always_ff @(posedge clock) begin
      rd_time_ff  <= times_mem[rd_addr];
      rd_value_ff <= values_mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temperature_ff;
   assign rsp_segment     = rsp_segment_ff;
   assign rsp_past_end    = rsp_past_end_ff;

`ifndef SYNTHESIS
   // pointer stays inside the table once the segment is read
   a_ptr_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEG0) |-> (ptr_ff <= last_slot))
      else $error("segment pointer beyond last breakpoint");

   // end flag agrees with the pointer
   a_end_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEG0) |-> (at_end_ff == (ptr_ff == last_slot)))
      else $error("end flag disagrees with segment pointer");

   // divider never runs past its step count
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (cnt_ff < DIV_CNT_W'(DIV_STEPS)))
      else $error("divider step count overrun");

   // a new result only comes out of the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("result raised outside the output step");

   // hold requests off while the sequencer is busy
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request accepted while busy");
`endif

endmodule
